// ----- sv/spk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spk_pkg;

    // cipher geometry
    localparam int WORD_W     = 64;
    localparam int ROUNDS     = 33;
    localparam int RIDX_W     = $clog2(ROUNDS);
    localparam int CFG_ADDR_W = 5;

    localparam logic [RIDX_W-1:0] RIDX_LAST = RIDX_W'(ROUNDS - 1);
    localparam logic [RIDX_W-1:0] XSTEP_LAST = RIDX_W'(ROUNDS - 2);

    // register indexes on the config port
    localparam logic [1:0] REG_KEY0 = 2'd0;
    localparam logic [1:0] REG_KEY1 = 2'd1;
    localparam logic [1:0] REG_KEY2 = 2'd2;

    // round unit direction
    typedef enum logic
    {
        OP_FWD,
        OP_INV
    } spk_op_t;

    // sequencer states
    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_RUN,
        ST_FIN
    } spk_state_t;

    // key words and schedule status from the config block
    typedef struct packed
    {
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] l0;
        logic [WORD_W-1:0] l1;
        logic              stale;
    } spk_key_t;

endpackage

`default_nettype wire

// ----- sv/spk_round.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spk_round
(
    input  spk_pkg::spk_op_t                 op,
    input  logic [spk_pkg::WORD_W-1:0]       x,
    input  logic [spk_pkg::WORD_W-1:0]       y,
    input  logic [spk_pkg::WORD_W-1:0]       rk,
    output logic [spk_pkg::WORD_W-1:0]       x_out,
    output logic [spk_pkg::WORD_W-1:0]       y_out
);

    import spk_pkg::*;

    logic [WORD_W-1:0] x_ror8;
    logic [WORD_W-1:0] y_rol3;
    logic [WORD_W-1:0] xy_mix;
    logic [WORD_W-1:0] y_inv;
    logic [WORD_W-1:0] add_a;
    logic [WORD_W-1:0] add_b;
    logic              add_cin;
    logic [WORD_W-1:0] sum;

    // fixed rotations
    assign x_ror8 = {x[7:0], x[WORD_W-1:8]};
    assign y_rol3 = {y[WORD_W-4:0], y[WORD_W-1:WORD_W-3]};
    assign xy_mix = y ^ x;
    assign y_inv  = {xy_mix[2:0], xy_mix[WORD_W-1:3]};

    // shared adder, subtracts in the inverse direction
    always_comb
    begin
        case (op)
            OP_FWD:
            begin
                add_a   = x_ror8;
                add_b   = y;
                add_cin = 1'b0;
            end
            default:
            begin
                add_a   = x ^ rk;
                add_b   = ~y_inv;
                add_cin = 1'b1;
            end
        endcase
    end

    assign sum = add_a + add_b + {{(WORD_W-1){1'b0}}, add_cin};

    // round outputs
    always_comb
    begin
        case (op)
            OP_FWD:
            begin
                x_out = sum ^ rk;
                y_out = y_rol3 ^ (sum ^ rk);
            end
            default:
            begin
                x_out = {sum[WORD_W-9:0], sum[WORD_W-1:WORD_W-8]};
                y_out = y_inv;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/spk_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spk_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [spk_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [spk_pkg::WORD_W-1:0]       pwdata,
    output logic [spk_pkg::WORD_W-1:0]       prdata,
    input  logic                             key_clear,
    output spk_pkg::spk_key_t                keys
);

    import spk_pkg::*;

    logic [WORD_W-1:0] k0_reg;
    logic [WORD_W-1:0] l0_reg;
    logic [WORD_W-1:0] l1_reg;
    logic              stale_reg;
    logic [1:0]        reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[4:3];
    assign wr_en   = psel & penable & pwrite;

    // key registers and stale flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k0_reg    <= '0;
            l0_reg    <= '0;
            l1_reg    <= '0;
            stale_reg <= 1'b1;
        end
        else
        begin
            if (key_clear)
            begin
                stale_reg <= 1'b0;
            end
            if (wr_en)
            begin
                unique case (reg_idx)
                    REG_KEY0:
                    begin
                        k0_reg    <= pwdata;
                        stale_reg <= 1'b1;
                    end
                    REG_KEY1:
                    begin
                        l0_reg    <= pwdata;
                        stale_reg <= 1'b1;
                    end
                    REG_KEY2:
                    begin
                        l1_reg    <= pwdata;
                        stale_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_KEY0: prdata = k0_reg;
            REG_KEY1: prdata = l0_reg;
            REG_KEY2: prdata = l1_reg;
            default:  prdata = '0;
        endcase
    end

    assign keys.k0    = k0_reg;
    assign keys.l0    = l0_reg;
    assign keys.l1    = l1_reg;
    assign keys.stale = stale_reg;

endmodule

`default_nettype wire

// ----- sv/speck_128_192_block_cipher_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake           | payload
// ----------+---------------------+------------------------------
// block in  | blk_valid/blk_stall | cmd, block_hi, block_lo
// result    | res_valid/res_stall | result_hi, result_lo
// config    | apb psel/penable    | paddr, pwdata, prdata (64b)
//
// an item goes through load, 33 rounds and output on the one round unit
// after reset or a key write the first item adds a key expansion first
// that reuses the same round unit, one round key written per cycle
// the round key table is a 33-entry memory with a registered read port
// blk_stall is high while an item is in flight; a waiting result holds in the
// output register and the engine stays in its final state until it drains

module speck_128_192_block_cipher_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             blk_valid,
    output logic                             blk_stall,
    input  logic                             cmd,
    input  logic [63:0]                      block_hi,
    input  logic [63:0]                      block_lo,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [63:0]                      result_hi,
    output logic [63:0]                      result_lo,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [spk_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [63:0]                      pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready
);

    import spk_pkg::*;

    spk_state_t        state_reg;
    spk_state_t        state_next;
    logic [RIDX_W-1:0] cnt_reg;
    spk_op_t           op_reg;
    logic [WORD_W-1:0] x_reg;
    logic [WORD_W-1:0] y_reg;
    logic [WORD_W-1:0] la_reg;
    logic [WORD_W-1:0] lb_reg;
    logic [WORD_W-1:0] kk_reg;
    logic [WORD_W-1:0] rk_reg;
    logic [WORD_W-1:0] res_hi_reg;
    logic [WORD_W-1:0] res_lo_reg;
    logic              res_valid_reg;

    logic [WORD_W-1:0] rk_mem [ROUNDS];

    spk_key_t          keys;
    logic              key_clear;
    logic              accept;
    logic              out_free;
    logic              mem_we;
    logic [RIDX_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [RIDX_W-1:0] rd_addr;
    logic [RIDX_W-1:0] nxt_round;

    spk_op_t           u_op;
    logic [WORD_W-1:0] u_x;
    logic [WORD_W-1:0] u_y;
    logic [WORD_W-1:0] u_rk;
    logic [WORD_W-1:0] u_x_out;
    logic [WORD_W-1:0] u_y_out;

    assign accept   = blk_valid & ~blk_stall;
    assign out_free = ~res_valid_reg | ~res_stall;
    assign pready   = 1'b1;

    // config registers
    spk_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .key_clear (key_clear),
        .keys      (keys)
    );

    // shared round unit, key expansion runs it forward with the step index as key
    always_comb
    begin
        if (state_reg == ST_EXPAND)
        begin
            u_op = OP_FWD;
            u_x  = la_reg;
            u_y  = kk_reg;
            u_rk = WORD_W'(cnt_reg);
        end
        else
        begin
            u_op = op_reg;
            u_x  = x_reg;
            u_y  = y_reg;
            u_rk = rk_reg;
        end
    end

    spk_round u_round
    (
        .op    (u_op),
        .x     (u_x),
        .y     (u_y),
        .rk    (u_rk),
        .x_out (u_x_out),
        .y_out (u_y_out)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = keys.stale ? ST_EXPAND : ST_LOAD;
                end
            end
            ST_EXPAND:
            begin
                if (cnt_reg == XSTEP_LAST)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (cnt_reg == RIDX_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // next round index to prefetch
    assign nxt_round = (cnt_reg == RIDX_LAST) ? cnt_reg : cnt_reg + 1'b1;

    // sequencer outputs, stall is low in idle so valid alone marks an accept
    always_comb
    begin
        blk_stall = 1'b1;
        key_clear = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = keys.k0;
        rd_addr   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                blk_stall = 1'b0;
                if (blk_valid && keys.stale)
                begin
                    key_clear = 1'b1;
                    mem_we    = 1'b1;
                end
            end
            ST_EXPAND:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg + 1'b1;
                mem_wdata = u_y_out;
            end
            ST_LOAD:
            begin
                rd_addr = (op_reg == OP_FWD) ? '0 : RIDX_LAST;
            end
            ST_RUN:
            begin
                rd_addr = (op_reg == OP_FWD) ? nxt_round : RIDX_LAST - nxt_round;
            end
            ST_FIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // round key memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rk_mem[mem_waddr] <= mem_wdata;
        end
        rk_reg <= rk_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_EXPAND:
                begin
                    cnt_reg <= (cnt_reg == XSTEP_LAST) ? '0 : cnt_reg + 1'b1;
                end
                ST_RUN:
                begin
                    cnt_reg <= (cnt_reg == RIDX_LAST) ? '0 : cnt_reg + 1'b1;
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
            if (state_reg == ST_FIN && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= cmd ? OP_INV : OP_FWD;
            x_reg  <= block_hi;
            y_reg  <= block_lo;
            kk_reg <= keys.k0;
            la_reg <= keys.l0;
            lb_reg <= keys.l1;
        end
        if (state_reg == ST_EXPAND)
        begin
            la_reg <= lb_reg;
            lb_reg <= u_x_out;
            kk_reg <= u_y_out;
        end
        if (state_reg == ST_RUN)
        begin
            x_reg <= u_x_out;
            y_reg <= u_y_out;
        end
        if (state_reg == ST_FIN && out_free)
        begin
            res_hi_reg <= x_reg;
            res_lo_reg <= y_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign result_hi = res_hi_reg;
    assign result_lo = res_lo_reg;

    // an accepted item always leaves the idle state
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("engine stayed idle after taking an item");

    // stale keys force an expansion before the rounds
    a_stale_expands: assert property (@(posedge clk) disable iff (!rst_n)
        accept && keys.stale |=> state_reg == ST_EXPAND && !keys.stale)
        else $error("stale key schedule not rebuilt");

    // round counter never leaves the table range
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= RIDX_LAST)
        else $error("round counter out of range");

    // a finished block lands in the output register once it is free
    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN && out_free |=> res_valid_reg && state_reg == ST_IDLE)
        else $error("finished block not delivered");

    // expansion always ends on the last table entry
    a_expand_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXPAND && state_next == ST_LOAD |-> mem_waddr == RIDX_LAST)
        else $error("key expansion ended early");

endmodule

`default_nettype wire

// ----- tb/tb_speck_128_192_block_cipher_top.sv -----
`timescale 1ns / 1ps

module tb_speck_128_192_block_cipher_top;

    import spk_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_SEGS = 4;
    localparam int SEG_ITEMS   = 140;
    localparam int DRAIN_WAIT  = 72;

    // index past the last key register, used to check that it is ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed
    {
        spk_op_t           op;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
    } block_item_t;

    typedef struct packed
    {
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
    } cipher_out_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              blk_valid = 1'b0;
    logic              blk_stall;
    logic              cmd = 1'b0;
    logic [63:0]       block_hi = '0;
    logic [63:0]       block_lo = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    logic [63:0]       result_hi;
    logic [63:0]       result_lo;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [63:0]       pwdata = '0;
    logic [63:0]       prdata;
    logic              pready;

    // local copy of key words and expanded schedule
    logic [WORD_W-1:0] key_w [0:2];
    logic [WORD_W-1:0] round_key [0:ROUNDS-1];

    block_item_t block_in_q [$];
    cipher_out_t cipher_out_q [$];
    block_item_t on_wire;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int cycle_count = 0;

    speck_128_192_block_cipher_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_valid (blk_valid),
        .blk_stall (blk_stall),
        .cmd       (cmd),
        .block_hi  (block_hi),
        .block_lo  (block_lo),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .result_hi (result_hi),
        .result_lo (result_lo),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] rot_r(input logic [63:0] v, input int s);
        return (v >> s) | (v << (64 - s));
    endfunction

    function automatic logic [63:0] rot_l(input logic [63:0] v, input int s);
        return (v << s) | (v >> (64 - s));
    endfunction

    // key expansion into the round key table
    function automatic void expand_key_schedule();
        logic [WORD_W-1:0] lw [0:ROUNDS];
        logic [WORD_W-1:0] kk;
        kk = key_w[0];
        lw[0] = key_w[1];
        lw[1] = key_w[2];
        round_key[0] = kk;
        for (int i = 0; i < ROUNDS - 1; i++)
        begin
            lw[i + 2] = (kk + rot_r(lw[i], 8)) ^ 64'(i);
            kk = rot_l(kk, 3) ^ lw[i + 2];
            round_key[i + 1] = kk;
        end
    endfunction

    // full 33-round encrypt or decrypt of one block
    function automatic cipher_out_t speck_transform(input block_item_t blk);
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        cipher_out_t r;
        x = blk.hi;
        y = blk.lo;
        if (blk.op == OP_FWD)
        begin
            for (int i = 0; i < ROUNDS; i++)
            begin
                x = (rot_r(x, 8) + y) ^ round_key[i];
                y = rot_l(y, 3) ^ x;
            end
        end
        else
        begin
            for (int i = ROUNDS - 1; i >= 0; i--)
            begin
                y = rot_r(y ^ x, 3);
                x = rot_l((x ^ round_key[i]) - y, 8);
            end
        end
        r.hi = x;
        r.lo = y;
        return r;
    endfunction

    // word with a bias toward extremes and single set or cleared bits
    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'(1) << $urandom_range(0, 63);
            3: return ~(64'(1) << $urandom_range(0, 63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // block driver
    always @(posedge clk)
    begin
        logic taken;
        block_item_t nxt;
        if (rst_n)
        begin
            taken = blk_valid && !blk_stall;
            if (taken)
                cipher_out_q.push_back(speck_transform(on_wire));
            if (!blk_valid || taken)
            begin
                if (block_in_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = block_in_q.pop_front();
                    on_wire <= nxt;
                    blk_valid <= 1'b1;
                    cmd <= nxt.op;
                    block_hi <= nxt.hi;
                    block_lo <= nxt.lo;
                end
                else
                begin
                    blk_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge clk)
    begin
        cipher_out_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (cipher_out_q.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, got %h %h",
                             $time, result_hi, result_lo);
                    errors++;
                end
                else
                begin
                    want = cipher_out_q.pop_front();
                    if (result_hi !== want.hi)
                    begin
                        $display("%0t result_hi mismatch: expected %h, got %h",
                                 $time, want.hi, result_hi);
                        errors++;
                    end
                    if (result_lo !== want.lo)
                    begin
                        $display("%0t result_lo mismatch: expected %h, got %h",
                                 $time, want.lo, result_lo);
                        errors++;
                    end
                end
            end
            res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic apb_xfer(input logic wr, input logic [1:0] idx,
                            input logic [63:0] wdata, output logic [63:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 3'b000};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
        logic [63:0] unused;
        apb_xfer(1'b1, idx, val, unused);
        if (idx != REG_UNUSED)
        begin
            key_w[idx] = val;
            expand_key_schedule();
        end
    endtask

    task automatic check_key_regs();
        logic [63:0] rd;
        for (int i = 0; i < 3; i++)
        begin
            apb_xfer(1'b0, 2'(i), '0, rd);
            if (rd !== key_w[i])
            begin
                $display("%0t key register %0d readback: expected %h, got %h",
                         $time, i, key_w[i], rd);
                errors++;
            end
        end
    endtask

    task automatic add_block(input spk_op_t op, input logic [63:0] hi, input logic [63:0] lo);
        block_item_t b;
        b.op = op;
        b.hi = hi;
        b.lo = lo;
        block_in_q.push_back(b);
    endtask

    // encrypt a block, then decrypt its ciphertext back
    task automatic add_round_trip(input logic [63:0] hi, input logic [63:0] lo);
        block_item_t b;
        cipher_out_t ct;
        b.op = OP_FWD;
        b.hi = hi;
        b.lo = lo;
        ct = speck_transform(b);
        block_in_q.push_back(b);
        add_block(OP_INV, ct.hi, ct.lo);
    endtask

    task automatic wait_idle();
        while (block_in_q.size() != 0 || blk_valid || cipher_out_q.size() != 0)
            @(negedge clk);
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        key_w[0] = '0;
        key_w[1] = '0;
        key_w[2] = '0;
        expand_key_schedule();
        send_idle_pct = 24;
        recv_idle_pct = 63;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset keys, first block forces the initial expansion
        check_key_regs();
        add_block(OP_FWD, '0, '0);
        add_block(OP_INV, '0, '0);
        add_block(OP_FWD, '1, '1);
        add_block(OP_INV, '1, '1);
        wait_idle();

        // standard test key
        write_key(REG_KEY0, 64'h0706050403020100);
        write_key(REG_KEY1, 64'h0f0e0d0c0b0a0908);
        write_key(REG_KEY2, 64'h1716151413121110);
        check_key_regs();
        add_block(OP_FWD, 64'h7261482066656968, 64'h43206f7420746e65);
        add_round_trip('0, '1);
        add_round_trip('1, '0);
        add_round_trip(64'h8000000000000000, 64'h1);
        add_block(OP_INV, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        wait_idle();

        // rewriting the same key value re-expands, results unchanged
        write_key(REG_KEY1, key_w[1]);
        add_block(OP_FWD, 64'h1, 64'h8000000000000000);
        add_block(OP_INV, 64'h0123456789abcdef, 64'hfedcba9876543210);
        wait_idle();

        // write past the last register is ignored
        write_key(REG_UNUSED, 64'hdeadbeefcafef00d);
        check_key_regs();
        add_block(OP_FWD, 64'h1, 64'h8000000000000000);
        add_block(OP_INV, '0, '1);
        wait_idle();

        // all-ones key
        write_key(REG_KEY0, '1);
        write_key(REG_KEY1, '1);
        write_key(REG_KEY2, '1);
        check_key_regs();
        add_block(OP_FWD, '0, '0);
        add_block(OP_INV, '0, '0);
        add_round_trip('1, '1);

        // random part, three idling mixes, some keys renewed per segment
        for (int mode = 0; mode < 3; mode++)
        begin
            for (int seg = 0; seg < RANDOM_SEGS; seg++)
            begin
                wait_idle();
                case (mode)
                    0:
                    begin
                        send_idle_pct = 24;
                        recv_idle_pct = 63;
                    end
                    1:
                    begin
                        send_idle_pct = 63;
                        recv_idle_pct = 24;
                    end
                    default:
                    begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                endcase
                for (int r = 0; r < 3; r++)
                begin
                    if (seg == 0 || $urandom_range(0, 2) != 0)
                        write_key(2'(r), pick_word());
                end
                if ($urandom_range(0, 3) == 0)
                    write_key(REG_UNUSED, pick_word());
                check_key_regs();
                for (int n = 0; n < SEG_ITEMS; n++)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        add_round_trip(pick_word(), pick_word());
                        n++;
                    end
                    else
                    begin
                        add_block($urandom_range(0, 1) ? OP_INV : OP_FWD,
                                  pick_word(), pick_word());
                    end
                end
            end
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0 && cipher_out_q.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
